### design/cvm_pkg.sv
// cvm_pkg: shared constants, codes and item types of the sliding-window convolver
// used by every module of the block; depends on nothing
`default_nettype none

package cvm_pkg;

    // geometry limits
    localparam int MAX_IMAGE  = 64;
    localparam int MAX_KERNEL = 5;
    localparam int TAP_COUNT  = MAX_KERNEL * MAX_KERNEL;

    // field widths
    localparam int IMG_W    = 7;
    localparam int KER_W    = 3;
    localparam int TAP_IN_W = 5;
    localparam int SAMPLE_W = 16;
    localparam int ACC_W    = 37;
    localparam int POS_W    = 6;

    // derived internal widths
    localparam int COL_W     = (MAX_IMAGE > 1) ? $clog2(MAX_IMAGE) : 1;
    localparam int SLOT_W    = (MAX_KERNEL > 1) ? $clog2(MAX_KERNEL) : 1;
    localparam int TAP_IDX_W = (TAP_COUNT > 1) ? $clog2(TAP_COUNT) : 1;
    localparam int PROD_W    = 2 * SAMPLE_W;

    // register port
    localparam int ADDR_W = 3;
    localparam int DATA_W = 32;

    // queue between front and back
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // request codes
    localparam logic REQ_TAP   = 1'b0;
    localparam logic REQ_PIXEL = 1'b1;

    // register indexes
    localparam logic REG_IMAGE  = 1'b0;
    localparam logic REG_KERNEL = 1'b1;

    // register reset values
    localparam logic [IMG_W-1:0] IMAGE_RESET  = IMG_W'(32);
    localparam logic [KER_W-1:0] KERNEL_RESET = KER_W'(3);

    // input item
    typedef struct packed {
        logic                       req_type;
        logic [TAP_IN_W-1:0]        tap_index;
        logic signed [SAMPLE_W-1:0] sample;
    } t_in_item;

    // result item
    typedef struct packed {
        logic signed [ACC_W-1:0] conv_value;
        logic [POS_W-1:0]        out_row;
        logic [POS_W-1:0]        out_col;
        logic                    frame_end;
    } t_out_item;

    // classified item passed from front to back
    typedef struct packed {
        logic                       is_pixel;
        logic                       tap_ok;
        logic [TAP_IDX_W-1:0]       tap_addr;
        logic signed [SAMPLE_W-1:0] sample;
        logic [COL_W-1:0]           col;
        logic [SLOT_W-1:0]          slot;
        logic                       emit;
        logic [POS_W-1:0]           out_row;
        logic [POS_W-1:0]           out_col;
        logic                       frame_end;
    } t_cmd;

endpackage

`default_nettype wire

### design/cvm_front.sv
// cvm_front: register port, raster counters and item classification
// depends on cvm_pkg
`default_nettype none

module cvm_front (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_in_valid,
    input  wire cvm_pkg::t_in_item         i_in_item,
    input  wire logic                      i_push_stall,
    output logic                           o_push_valid,
    output cvm_pkg::t_cmd                  o_push_cmd,
    output logic [cvm_pkg::KER_W-1:0]      o_kernel,
    input  wire logic                      psel,
    input  wire logic                      penable,
    input  wire logic                      pwrite,
    input  wire logic [cvm_pkg::ADDR_W-1:0] paddr,
    input  wire logic [cvm_pkg::DATA_W-1:0] pwdata,
    output logic [cvm_pkg::DATA_W-1:0]     prdata,
    output logic                           pready
);
    import cvm_pkg::*;

    logic [IMG_W-1:0]  r_image_size;
    logic [KER_W-1:0]  r_kernel_size;
    logic [COL_W-1:0]  r_row;
    logic [COL_W-1:0]  r_col;
    logic [SLOT_W-1:0] r_slot;

    logic [IMG_W-1:0]  s_n;
    logic [KER_W-1:0]  s_k;
    logic [IMG_W-1:0]  s_kn;
    logic [IMG_W-1:0]  s_row_p1;
    logic [IMG_W-1:0]  s_col_p1;
    logic              s_last_col;
    logic              s_last;
    logic              s_emit;
    logic              s_accept;
    logic              s_cfg_wr;
    logic              s_reg_idx;

    // register access decode
    assign pready    = 1'b1;
    assign s_cfg_wr  = psel && penable && pwrite;
    assign s_reg_idx = paddr[ADDR_W-1];

    always_comb begin
        unique case (s_reg_idx)
            REG_IMAGE:  prdata = DATA_W'(r_image_size);
            REG_KERNEL: prdata = DATA_W'(r_kernel_size);
        endcase
    end

    // clamp register values to the supported range
    always_comb begin
        if (r_image_size == '0) begin
            s_n = IMG_W'(1);
        end else if (r_image_size > IMG_W'(MAX_IMAGE)) begin
            s_n = IMG_W'(MAX_IMAGE);
        end else begin
            s_n = r_image_size;
        end
        if (r_kernel_size == '0) begin
            s_k = KER_W'(1);
        end else if (r_kernel_size > KER_W'(MAX_KERNEL)) begin
            s_k = KER_W'(MAX_KERNEL);
        end else begin
            s_k = r_kernel_size;
        end
    end

    assign o_kernel = s_k;

    // raster position and window completion
    assign s_kn       = IMG_W'(s_k);
    assign s_row_p1   = IMG_W'(r_row) + IMG_W'(1);
    assign s_col_p1   = IMG_W'(r_col) + IMG_W'(1);
    assign s_last_col = (s_col_p1 == s_n);
    assign s_last     = s_last_col && (s_row_p1 == s_n);
    assign s_emit     = (s_kn <= s_n) && (s_row_p1 >= s_kn) && (s_col_p1 >= s_kn);

    assign s_accept     = i_in_valid && !i_push_stall;
    assign o_push_valid = i_in_valid;

    // classified item
    always_comb begin
        o_push_cmd.is_pixel  = (i_in_item.req_type == REQ_PIXEL);
        o_push_cmd.tap_ok    = (i_in_item.tap_index < TAP_IN_W'(TAP_COUNT));
        o_push_cmd.tap_addr  = TAP_IDX_W'(i_in_item.tap_index);
        o_push_cmd.sample    = i_in_item.sample;
        o_push_cmd.col       = r_col;
        o_push_cmd.slot      = r_slot;
        o_push_cmd.emit      = s_emit;
        o_push_cmd.out_row   = POS_W'(s_row_p1 - s_kn);
        o_push_cmd.out_col   = POS_W'(s_col_p1 - s_kn);
        o_push_cmd.frame_end = s_last;
    end

    // registers and raster counters; a register write restarts the frame
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_image_size  <= IMAGE_RESET;
            r_kernel_size <= KERNEL_RESET;
            r_row         <= '0;
            r_col         <= '0;
            r_slot        <= '0;
        end else if (s_cfg_wr) begin
            unique case (s_reg_idx)
                REG_IMAGE:  r_image_size  <= pwdata[IMG_W-1:0];
                REG_KERNEL: r_kernel_size <= pwdata[KER_W-1:0];
            endcase
            r_row  <= '0;
            r_col  <= '0;
            r_slot <= '0;
        end else if (s_accept && i_in_item.req_type == REQ_PIXEL) begin
            if (s_last_col) begin
                r_col <= '0;
                if (s_last) begin
                    r_row  <= '0;
                    r_slot <= '0;
                end else begin
                    r_row  <= r_row + COL_W'(1);
                    r_slot <= (r_slot == SLOT_W'(MAX_KERNEL - 1)) ? '0 : r_slot + SLOT_W'(1);
                end
            end else begin
                r_col <= r_col + COL_W'(1);
            end
        end
    end

endmodule

`default_nettype wire

### design/cvm_queue.sv
// cvm_queue: short first-in first-out queue of classified items
// depends on cvm_pkg
`default_nettype none

module cvm_queue (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_push_valid,
    output logic               o_push_stall,
    input  wire cvm_pkg::t_cmd i_push_cmd,
    output logic               o_pop_valid,
    input  wire logic          i_pop_stall,
    output cvm_pkg::t_cmd      o_pop_cmd
);
    import cvm_pkg::*;

    t_cmd              r_slots [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wptr;
    logic [QPTR_W-1:0] r_rptr;
    logic [QCNT_W-1:0] r_count;
    logic              s_push;
    logic              s_pop;

    // fill state
    assign o_push_stall = (r_count == QCNT_W'(QUEUE_DEPTH));
    assign o_pop_valid  = (r_count != '0);
    assign o_pop_cmd    = r_slots[r_rptr];
    assign s_push       = i_push_valid && !o_push_stall;
    assign s_pop        = o_pop_valid && !i_pop_stall;

    // storage
    always_ff @(posedge i_clk) begin
        if (s_push) begin
            r_slots[r_wptr] <= i_push_cmd;
        end
    end

    // pointers and count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (s_push) begin
                r_wptr <= (r_wptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wptr + QPTR_W'(1);
            end
            if (s_pop) begin
                r_rptr <= (r_rptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rptr + QPTR_W'(1);
            end
            case ({s_push, s_pop})
                2'b10:   r_count <= r_count + QCNT_W'(1);
                2'b01:   r_count <= r_count - QCNT_W'(1);
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

`default_nettype wire

### design/cvm_back.sv
// cvm_back: line store, sliding window, tap bank, multipliers and adder tree
// depends on cvm_pkg
`default_nettype none

module cvm_back (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic [cvm_pkg::KER_W-1:0] i_kernel,
    input  wire logic                 i_q_valid,
    input  wire cvm_pkg::t_cmd        i_q_cmd,
    output logic                      o_q_stall,
    output logic                      o_out_valid,
    input  wire logic                 i_out_stall,
    output cvm_pkg::t_out_item        o_out_item
);
    import cvm_pkg::*;

    typedef struct packed {
        logic [POS_W-1:0] row;
        logic [POS_W-1:0] col;
        logic             frame_end;
    } t_tag;

    logic                       s_adv;

    // line store: one bank per row slot
    logic signed [SAMPLE_W-1:0] r_line [MAX_KERNEL][MAX_IMAGE];
    logic signed [SAMPLE_W-1:0] r_rd [MAX_KERNEL];

    logic                       r_b_valid;
    t_cmd                       r_b_cmd;
    logic signed [SAMPLE_W-1:0] r_taps [TAP_COUNT];
    logic signed [SAMPLE_W-1:0] r_win [MAX_KERNEL][MAX_KERNEL];
    logic signed [SAMPLE_W-1:0] s_colv [MAX_KERNEL];
    logic signed [SAMPLE_W-1:0] s_tap_sel [MAX_KERNEL][MAX_KERNEL];
    logic                       s_tap_on [MAX_KERNEL][MAX_KERNEL];

    logic                       r_c_valid;
    t_tag                       r_c_tag;
    logic signed [PROD_W-1:0]   r_prod [MAX_KERNEL][MAX_KERNEL];

    logic                       r_d_valid;
    t_tag                       r_d_tag;
    logic signed [ACC_W-1:0]    s_part [MAX_KERNEL];
    logic signed [ACC_W-1:0]    r_part [MAX_KERNEL];

    logic                       r_e_valid;
    t_tag                       r_e_tag;
    logic signed [ACC_W-1:0]    s_total;

    logic                       r_out_valid;
    t_out_item                  r_out;

    // whole pipeline moves unless a finished result is held
    assign s_adv       = !r_out_valid || !i_out_stall;
    assign o_q_stall   = !s_adv;
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

    // line store read of the column and write of the new pixel
    always_ff @(posedge i_clk) begin
        if (s_adv && i_q_valid) begin
            for (int b = 0; b < MAX_KERNEL; b++) begin
                r_rd[b] <= r_line[b][i_q_cmd.col];
                if (i_q_cmd.is_pixel && i_q_cmd.slot == SLOT_W'(b)) begin
                    r_line[b][i_q_cmd.col] <= i_q_cmd.sample;
                end
            end
        end
    end

    // column of the window: depth d holds the pixel d rows above the current one
    always_comb begin
        for (int d = 0; d < MAX_KERNEL; d++) begin
            s_colv[d] = '0;
            if (d == 0) begin
                s_colv[d] = r_b_cmd.sample;
            end else begin
                for (int b = 0; b < MAX_KERNEL; b++) begin
                    if ((int'(r_b_cmd.slot) - d == b) ||
                        (int'(r_b_cmd.slot) + MAX_KERNEL - d == b)) begin
                        s_colv[d] = r_rd[b];
                    end
                end
            end
        end
    end

    // tap aligned to window position: age j columns back, depth d rows up
    always_comb begin
        for (int j = 0; j < MAX_KERNEL; j++) begin
            for (int d = 0; d < MAX_KERNEL; d++) begin
                s_tap_sel[j][d] = '0;
                s_tap_on[j][d]  = 1'b0;
            end
        end
        for (int kv = 1; kv <= MAX_KERNEL; kv++) begin
            if (int'(i_kernel) == kv) begin
                for (int j = 0; j < kv; j++) begin
                    for (int d = 0; d < kv; d++) begin
                        s_tap_sel[j][d] = r_taps[(kv - 1 - d) * kv + (kv - 1 - j)];
                        s_tap_on[j][d]  = 1'b1;
                    end
                end
            end
        end
    end

    // partial sums over each window row, then the total
    always_comb begin
        for (int d = 0; d < MAX_KERNEL; d++) begin
            s_part[d] = '0;
            for (int j = 0; j < MAX_KERNEL; j++) begin
                s_part[d] = s_part[d] + ACC_W'(r_prod[j][d]);
            end
        end
        s_total = '0;
        for (int d = 0; d < MAX_KERNEL; d++) begin
            s_total = s_total + r_part[d];
        end
    end

    // stage valids
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid   <= 1'b0;
            r_c_valid   <= 1'b0;
            r_d_valid   <= 1'b0;
            r_e_valid   <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (s_adv) begin
            r_b_valid   <= i_q_valid;
            r_c_valid   <= r_b_valid && r_b_cmd.is_pixel && r_b_cmd.emit;
            r_d_valid   <= r_c_valid;
            r_e_valid   <= r_d_valid;
            r_out_valid <= r_e_valid;
        end
    end

    // window shift, tap bank, products, sums and result
    always_ff @(posedge i_clk) begin
        if (s_adv) begin
            r_b_cmd <= i_q_cmd;
            if (r_b_valid && r_b_cmd.is_pixel) begin
                for (int j = MAX_KERNEL - 1; j > 0; j--) begin
                    for (int d = 0; d < MAX_KERNEL; d++) begin
                        r_win[j][d] <= r_win[j-1][d];
                    end
                end
                for (int d = 0; d < MAX_KERNEL; d++) begin
                    r_win[0][d] <= s_colv[d];
                end
            end
            if (r_b_valid && !r_b_cmd.is_pixel && r_b_cmd.tap_ok) begin
                r_taps[r_b_cmd.tap_addr] <= r_b_cmd.sample;
            end
            r_c_tag.row       <= r_b_cmd.out_row;
            r_c_tag.col       <= r_b_cmd.out_col;
            r_c_tag.frame_end <= r_b_cmd.frame_end;

            // positions outside the kernel give no product
            for (int j = 0; j < MAX_KERNEL; j++) begin
                for (int d = 0; d < MAX_KERNEL; d++) begin
                    if (s_tap_on[j][d]) begin
                        r_prod[j][d] <= r_win[j][d] * s_tap_sel[j][d];
                    end else begin
                        r_prod[j][d] <= '0;
                    end
                end
            end
            r_d_tag <= r_c_tag;

            for (int d = 0; d < MAX_KERNEL; d++) begin
                r_part[d] <= s_part[d];
            end
            r_e_tag <= r_d_tag;

            r_out.conv_value <= s_total;
            r_out.out_row    <= r_e_tag.row;
            r_out.out_col    <= r_e_tag.col;
            r_out.frame_end  <= r_e_tag.frame_end;
        end
    end

endmodule

`default_nettype wire

### design/conv2d_valid_mac.sv
// conv2d_valid_mac: streaming 2D valid convolution, Q8.8 samples, exact Q21.16 sums
// an accepted pixel passes the queue, then registered stages b, c, d, e and the output register
// throughput: one item (tap load or pixel) per cycle if not stalled, set by the 4-entry queue
// and the fully pipelined 25-multiplier window datapath with one line store bank per row slot
// reset: synchronous, clears counters, queue and pipeline valids; taps and line store keep data
`default_nettype none

module conv2d_valid_mac (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_in_valid,
    output logic                            o_in_stall,
    input  wire cvm_pkg::t_in_item          i_in_item,
    output logic                            o_out_valid,
    input  wire logic                       i_out_stall,
    output cvm_pkg::t_out_item              o_out_item,
    input  wire logic                       psel,
    input  wire logic                       penable,
    input  wire logic                       pwrite,
    input  wire logic [cvm_pkg::ADDR_W-1:0] paddr,
    input  wire logic [cvm_pkg::DATA_W-1:0] pwdata,
    output logic [cvm_pkg::DATA_W-1:0]      prdata,
    output logic                            pready
);
    import cvm_pkg::*;

    logic             s_push_valid;
    t_cmd             s_push_cmd;
    logic             s_q_valid;
    t_cmd             s_q_cmd;
    logic             s_q_stall;
    logic [KER_W-1:0] s_kernel;
    logic             s_cfg_wr;

    assign s_cfg_wr = psel && penable && pwrite;

    // front: registers, counters, classification
    cvm_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .i_in_item    (i_in_item),
        .i_push_stall (o_in_stall),
        .o_push_valid (s_push_valid),
        .o_push_cmd   (s_push_cmd),
        .o_kernel     (s_kernel),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    // queue between front and back
    cvm_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (s_push_valid),
        .o_push_stall (o_in_stall),
        .i_push_cmd   (s_push_cmd),
        .o_pop_valid  (s_q_valid),
        .i_pop_stall  (s_q_stall),
        .o_pop_cmd    (s_q_cmd)
    );

    // back: window datapath
    cvm_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_kernel    (s_kernel),
        .i_q_valid   (s_q_valid),
        .i_q_cmd     (s_q_cmd),
        .o_q_stall   (s_q_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_item  (o_out_item)
    );

    // the last window of a frame sits on the diagonal of the output map
    a_frame_end_diag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_item.frame_end |-> o_out_item.out_row == o_out_item.out_col)
        else $error("frame end result off the diagonal");

    // a full queue always offers an item to the back
    a_full_has_head: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> s_q_valid)
        else $error("queue reports full with no head item");

    // a register write restarts the raster at the origin
    a_cfg_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(s_cfg_wr) && s_push_valid && !o_in_stall && s_push_cmd.is_pixel
        |-> s_push_cmd.col == '0 && s_push_cmd.slot == '0)
        else $error("pixel after register write not at frame origin");

endmodule

`default_nettype wire

### tb/sv/tb_conv2d_valid_mac.sv
// tb_conv2d_valid_mac: self-checking bench for the streaming valid-window convolver
// predicts every window sum, position and frame flag and checks them in order
// depends on cvm_pkg and conv2d_valid_mac
`default_nettype none

module tb_conv2d_valid_mac;
    timeunit 1ns;
    timeprecision 1ps;
    import cvm_pkg::*;

    localparam int SETTLE_CYCLES = 16;
    localparam int PIXEL_GOAL    = 2000;
    localparam int HOLD_CYCLES   = 300;

    // expected window sums, kept in arrival order
    class conv_scoreboard;
        logic [IMG_W-1:0]           image_reg;
        logic [KER_W-1:0]           kernel_reg;
        logic signed [SAMPLE_W-1:0] taps [TAP_COUNT];
        logic signed [SAMPLE_W-1:0] line_store [MAX_KERNEL][MAX_IMAGE];
        int                         row_pos;
        int                         col_pos;
        t_out_item                  sums_due [$];
        int                         errors;

        function new();
            image_reg  = IMAGE_RESET;
            kernel_reg = KERNEL_RESET;
            row_pos    = 0;
            col_pos    = 0;
            errors     = 0;
            foreach (taps[i]) taps[i] = '0;
            foreach (line_store[i, j]) line_store[i][j] = '0;
        endfunction

        function int image_dim();
            if (image_reg == 0) return 1;
            return (image_reg > MAX_IMAGE) ? MAX_IMAGE : int'(image_reg);
        endfunction

        function int kernel_dim();
            if (kernel_reg == 0) return 1;
            return (kernel_reg > MAX_KERNEL) ? MAX_KERNEL : int'(kernel_reg);
        endfunction

        // any register write restarts the frame
        function void write_reg(logic idx, logic [DATA_W-1:0] value);
            if (idx == REG_IMAGE) image_reg = value[IMG_W-1:0];
            else kernel_reg = value[KER_W-1:0];
            row_pos = 0;
            col_pos = 0;
        endfunction

        // advance the raster position and queue the window sum if one completes
        function void note_item(t_in_item it);
            int        n, k, r, c;
            bit        frame_last;
            longint    acc;
            t_out_item sum;
            if (it.req_type == REQ_TAP) begin
                if (it.tap_index < TAP_COUNT) taps[it.tap_index] = it.sample;
                return;
            end
            n = image_dim();
            k = kernel_dim();
            r = (row_pos >= n) ? n - 1 : row_pos;
            c = (col_pos >= n) ? n - 1 : col_pos;
            line_store[r % MAX_KERNEL][c] = it.sample;
            frame_last = (r == n - 1) && (c == n - 1);
            if (c == n - 1) begin
                col_pos = 0;
                row_pos = frame_last ? 0 : r + 1;
            end else begin
                col_pos = c + 1;
                row_pos = r;
            end
            if (k > n || r + 1 < k || c + 1 < k) return;
            acc = 0;
            for (int u = 0; u < k; u++) begin
                for (int v = 0; v < k; v++) begin
                    acc += longint'(line_store[(r + 1 - k + u) % MAX_KERNEL][c + 1 - k + v])
                         * longint'(taps[u * k + v]);
                end
            end
            sum.conv_value = ACC_W'(acc);
            sum.out_row    = POS_W'(r + 1 - k);
            sum.out_col    = POS_W'(c + 1 - k);
            sum.frame_end  = frame_last;
            sums_due.insert(sums_due.size(), sum);
        endfunction

        function void check_result(t_out_item got);
            t_out_item want;
            if (sums_due.size() == 0) begin
                $display("%0t: unexpected result, got %p", $time, got);
                errors++;
                return;
            end
            want = sums_due.pop_front();
            if (got.conv_value !== want.conv_value) begin
                $display("%0t: conv_value expected %0d, got %0d", $time, want.conv_value,
                         got.conv_value);
                errors++;
            end
            if (got.out_row !== want.out_row) begin
                $display("%0t: out_row expected %0d, got %0d", $time, want.out_row, got.out_row);
                errors++;
            end
            if (got.out_col !== want.out_col) begin
                $display("%0t: out_col expected %0d, got %0d", $time, want.out_col, got.out_col);
                errors++;
            end
            if (got.frame_end !== want.frame_end) begin
                $display("%0t: frame_end expected %0b, got %0b", $time, want.frame_end,
                         got.frame_end);
                errors++;
            end
        endfunction

        function int pending();
            return sums_due.size();
        endfunction
    endclass

    logic              clk       = 1'b0;
    logic              rst_n     = 1'b0;
    logic              in_valid  = 1'b0;
    t_in_item          in_item   = '0;
    logic              out_stall = 1'b0;
    logic              psel      = 1'b0;
    logic              penable   = 1'b0;
    logic              pwrite    = 1'b0;
    logic [ADDR_W-1:0] paddr     = '0;
    logic [DATA_W-1:0] pwdata    = '0;
    wire logic              in_stall;
    wire logic              out_valid;
    wire t_out_item         out_item;
    wire logic [DATA_W-1:0] prdata;
    wire logic              pready;

    conv_scoreboard sb;

    conv2d_valid_mac u_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_item   (in_item),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_item  (out_item),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // mostly no gap, some short, a few long
    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 60) return 0;
        if (roll < 90) return $urandom_range(1, 3);
        if (roll < 97) return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic signed [SAMPLE_W-1:0] pick_sample();
        int roll;
        roll = $urandom_range(0, 7);
        if (roll == 0) return 16'sh8000;
        if (roll == 1) return 16'sh7fff;
        return SAMPLE_W'($urandom());
    endfunction

    function automatic t_in_item make_item(logic kind, int idx, logic signed [SAMPLE_W-1:0] val);
        t_in_item it;
        it.req_type  = kind;
        it.tap_index = TAP_IN_W'(idx);
        it.sample    = val;
        return it;
    endfunction

    // offer one item and hold it until the block takes it
    task automatic send_item(input t_in_item it, input bit no_gaps);
        int gap;
        in_item  <= it;
        in_valid <= 1'b1;
        do @(posedge clk); while (in_stall);
        sb.note_item(it);
        gap = no_gaps ? 0 : pick_gap();
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // setup and access phases, then the bus returns to idle
    task automatic apb_access(input logic wr, input logic idx, input logic [DATA_W-1:0] wdata,
                              output logic [DATA_W-1:0] rdata);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= ADDR_W'({idx, 2'b00});
        pwdata  <= wdata;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        rdata = prdata;
        if (wr) sb.write_reg(idx, wdata);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
    endtask

    // stop offering, let every expected sum come back, then let the pipe settle
    task automatic drain();
        in_valid <= 1'b0;
        do @(posedge clk); while (sb.pending() != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // write both registers with random upper bits, then read them back
    task automatic configure(input int img, input int ker);
        logic [DATA_W-1:0] rd;
        apb_access(1'b1, REG_IMAGE, ($urandom() << IMG_W) | DATA_W'(img), rd);
        apb_access(1'b1, REG_KERNEL, ($urandom() << KER_W) | DATA_W'(ker), rd);
        apb_access(1'b0, REG_IMAGE, '0, rd);
        if (rd !== DATA_W'(sb.image_reg)) begin
            $display("%0t: image_size read expected %0d, got %0d", $time, sb.image_reg, rd);
            sb.errors++;
        end
        apb_access(1'b0, REG_KERNEL, '0, rd);
        if (rd !== DATA_W'(sb.kernel_reg)) begin
            $display("%0t: kernel_size read expected %0d, got %0d", $time, sb.kernel_reg, rd);
            sb.errors++;
        end
    endtask

    // raster pixels with the odd tap load mixed in; returns pixels sent
    task automatic run_phase(input int img, input int ker, output int pixels);
        int n, count;
        bit no_gaps;
        configure(img, ker);
        n = sb.image_dim();
        if (n * n <= 256)
            count = $urandom_range(1, 3) * n * n
                  + ($urandom_range(0, 1) ? $urandom_range(0, n * n - 1) : 0);
        else
            count = $urandom_range(150, 400);
        no_gaps = ($urandom_range(0, 3) == 0);
        pixels = 0;
        while (pixels < count) begin
            if ($urandom_range(0, 19) == 0) begin
                send_item(make_item(REQ_TAP, $urandom_range(0, 31), SAMPLE_W'($urandom())),
                          no_gaps);
            end else begin
                send_item(make_item(REQ_PIXEL, $urandom_range(0, 31), pick_sample()), no_gaps);
                pixels++;
            end
        end
        drain();
    endtask

    // stimulus
    initial begin
        int fixed_img [] = '{1, 0, 2, 5, 4, 1, 64, 127, 64, 7, 6, 12, 3};
        int fixed_ker [] = '{1, 0, 2, 5, 5, 5, 5, 7, 1, 3, 6, 4, 2};
        int total, got;
        sb = new();
        total = 0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // load every tap with the most negative value, plus out-of-range loads that are dropped
        for (int i = 0; i < TAP_COUNT; i++)
            send_item(make_item(REQ_TAP, i, 16'sh8000), 1'b0);
        send_item(make_item(REQ_TAP, 31, 16'sh7fff), 1'b0);
        send_item(make_item(REQ_TAP, TAP_COUNT, 16'sh7fff), 1'b0);
        drain();

        // one 3x3 frame of extreme pixels: the largest positive window sum
        configure(3, 3);
        for (int i = 0; i < 9; i++)
            send_item(make_item(REQ_PIXEL, 0, 16'sh8000), 1'b0);
        drain();

        // fixed corner settings, then random ones, mostly small images
        foreach (fixed_img[i]) begin
            run_phase(fixed_img[i], fixed_ker[i], got);
            total += got;
        end
        while (total < PIXEL_GOAL) begin
            run_phase(($urandom_range(0, 9) == 0) ? $urandom_range(0, 127) : $urandom_range(1, 16),
                      $urandom_range(0, 7), got);
            total += got;
        end

        if (sb.errors == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

    // result side: random stalls in bursts, and two long hold-offs to back the block up
    initial begin
        int  stall_left, hold_left, taken, mode_left;
        bit  busy_mode;
        stall_left = 0;
        hold_left  = 0;
        taken      = 0;
        mode_left  = 0;
        busy_mode  = 1'b0;
        forever begin
            @(posedge clk);
            if (rst_n && out_valid && !out_stall) begin
                sb.check_result(out_item);
                taken++;
                if (taken == 100 || taken == 700) hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                out_stall <= 1'b1;
            end else begin
                if (mode_left == 0) begin
                    busy_mode = $urandom_range(0, 1);
                    mode_left = $urandom_range(50, 300);
                end else begin
                    mode_left--;
                end
                if (stall_left == 0 && busy_mode && $urandom_range(0, 3) == 0)
                    stall_left = pick_gap() + 1;
                out_stall <= (stall_left > 0);
                if (stall_left > 0) stall_left--;
            end
        end
    end

    // watchdog
    initial begin
        #20_000_000;
        $display("CHECK FAILED");
        $finish;
    end

endmodule

`default_nettype wire
